/* design/png_unf_pkg.sv */
// ----------------------------------------------------------------------------
// png_unf_pkg: shared types, constants and helper functions
// Sizes, filter type codes, register indexes, the pipeline item format and
// the small arithmetic helpers used by the scanline unfilter.
// ----------------------------------------------------------------------------
package png_unf_pkg;

    // Line store and pixel history sizes
    localparam int MAX_ROW_BYTES   = 8192;
    localparam int MAX_PIXEL_BYTES = 8;
    localparam int ADDR_W          = $clog2(MAX_ROW_BYTES);
    localparam int COL_W           = 14;
    localparam int SLOT_W          = $clog2(MAX_PIXEL_BYTES);
    localparam int DIST_W          = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 14;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES       = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 1'd1;

    // Filter type codes (anything else passes data through)
    localparam logic [7:0] FILT_SUB   = 8'd1;
    localparam logic [7:0] FILT_UP    = 8'd2;
    localparam logic [7:0] FILT_AVG   = 8'd3;
    localparam logic [7:0] FILT_PAETH = 8'd4;

    // One item moving from the accept side into the reconstruction stage
    typedef struct packed {
        logic              is_data;   // 0: filter byte, clears the history
        logic [7:0]        data;
        logic [7:0]        kind;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] col;
        logic              first_row;
        logic              last;
    } t_item;

    // Write request into the line store
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_wr_req;

    // Column modulo pixel distance (distance 1..8) without a divider.
    // Odd moduli use digit sums in a base that is 1 mod the divisor.
    function automatic logic [SLOT_W-1:0] mod_dist(input logic [COL_W-1:0] col,
                                                   input logic [DIST_W-1:0] span);
        logic [4:0]        s3;
        logic [2:0]        t3;
        logic [1:0]        r3;
        logic [5:0]        s5;
        logic [4:0]        t5;
        logic [2:0]        r5;
        logic [4:0]        s7;
        logic [3:0]        t7;
        logic [2:0]        r7;
        logic [2:0]        r6;
        logic [SLOT_W-1:0] res;

        // mod 3: base-4 digits
        s3 = 5'(col[1:0]) + 5'(col[3:2]) + 5'(col[5:4]) + 5'(col[7:6])
           + 5'(col[9:8]) + 5'(col[11:10]) + 5'(col[13:12]);
        t3 = 3'(s3[1:0]) + 3'(s3[3:2]) + 3'(s3[4]);
        if (t3 >= 3'd6) begin
            t3 = t3 - 3'd6;
        end else if (t3 >= 3'd3) begin
            t3 = t3 - 3'd3;
        end
        r3 = t3[1:0];

        // mod 5: base-16 digits
        s5 = 6'(col[3:0]) + 6'(col[7:4]) + 6'(col[11:8]) + 6'(col[13:12]);
        t5 = 5'(s5[3:0]) + 5'(s5[5:4]);
        if (t5 >= 5'd10) begin
            t5 = t5 - 5'd10;
        end
        if (t5 >= 5'd5) begin
            t5 = t5 - 5'd5;
        end
        r5 = t5[2:0];

        // mod 7: base-8 digits
        s7 = 5'(col[2:0]) + 5'(col[5:3]) + 5'(col[8:6]) + 5'(col[11:9])
           + 5'(col[13:12]);
        t7 = 4'(s7[2:0]) + 4'(s7[4:3]);
        if (t7 >= 4'd7) begin
            t7 = t7 - 4'd7;
        end
        r7 = t7[2:0];

        // mod 6: combine mod 3 with parity
        if (r3[0] == col[0]) begin
            r6 = {1'b0, r3};
        end else begin
            r6 = {1'b0, r3} + 3'd3;
        end

        case (span)
            4'd2:    res = SLOT_W'(col[0]);
            4'd3:    res = SLOT_W'(r3);
            4'd4:    res = SLOT_W'(col[1:0]);
            4'd5:    res = SLOT_W'(r5);
            4'd6:    res = SLOT_W'(r6);
            4'd7:    res = SLOT_W'(r7);
            4'd8:    res = SLOT_W'(col[2:0]);
            default: res = '0;
        endcase
        return res;
    endfunction

    // Paeth predictor: nearest of left, up, upper-left to left+up-upper-left
    function automatic logic [7:0] paeth_pred(input logic [7:0] a,
                                              input logic [7:0] b,
                                              input logic [7:0] c);
        logic signed [9:0] sa;
        logic signed [9:0] sb;
        logic signed [9:0] sc;
        logic signed [9:0] da;
        logic signed [9:0] db;
        logic signed [9:0] dc;
        logic [9:0]        pa;
        logic [9:0]        pb;
        logic [9:0]        pc;
        logic [7:0]        res;

        sa = $signed({2'b00, a});
        sb = $signed({2'b00, b});
        sc = $signed({2'b00, c});
        da = sb - sc;
        db = sa - sc;
        dc = sa + sb - sc - sc;
        pa = (da < 0) ? 10'(-da) : 10'(da);
        pb = (db < 0) ? 10'(-db) : 10'(db);
        pc = (dc < 0) ? 10'(-dc) : 10'(dc);
        if (pa <= pb && pa <= pc) begin
            res = a;
        end else if (pb <= pc) begin
            res = b;
        end else begin
            res = c;
        end
        return res;
    endfunction

endpackage

/* design/png_unf_line_store.sv */
// ----------------------------------------------------------------------------
// png_unf_line_store: prior-row byte memory
// One write port and one registered read port; a read at the address being
// written in the same cycle returns the old byte.
// ----------------------------------------------------------------------------
module png_unf_line_store
    import png_unf_pkg::*;
(
    input  logic              i_clk,
    input  t_wr_req           i_wr,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [7:0]        o_rd_data
);

    logic [7:0] r_mem [MAX_ROW_BYTES];
    logic [7:0] r_rd_data;

    // Write the reconstructed byte, read the byte above the next column
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/png_unf_ctrl.sv */
// ----------------------------------------------------------------------------
// png_unf_ctrl: configuration and row sequencing
// Holds the effective row length and pixel distance, tracks the column,
// the filter type and the first-row flag, and builds one item per transfer.
// ----------------------------------------------------------------------------
module png_unf_ctrl
    import png_unf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_accept,
    input  logic [7:0]            i_stream_byte,
    input  logic                  i_frame_start,
    output t_item                 o_item
);

    localparam logic [COL_W-1:0]  MaxLen  = COL_W'(MAX_ROW_BYTES);
    localparam logic [DIST_W-1:0] MaxDist = DIST_W'(MAX_PIXEL_BYTES);

    logic [COL_W-1:0]  r_row_len;
    logic [DIST_W-1:0] r_dist;
    logic [COL_W-1:0]  r_col;
    logic [7:0]        r_kind;
    logic              r_await;
    logic              r_first;

    logic              start_row;
    logic [COL_W-1:0]  col_c;
    logic [COL_W:0]    col_inc;
    logic              last;
    logic [COL_W-1:0]  cfg_len;
    logic [DIST_W-1:0] cfg_dist;

    // Saturate register values into their working ranges
    always_comb begin
        cfg_len  = i_cfg_data[COL_W-1:0];
        cfg_dist = i_cfg_data[DIST_W-1:0];
        if (cfg_len == '0) begin
            cfg_len = COL_W'(1);
        end else if (cfg_len > MaxLen) begin
            cfg_len = MaxLen;
        end
        if (cfg_dist == '0) begin
            cfg_dist = DIST_W'(1);
        end else if (cfg_dist > MaxDist) begin
            cfg_dist = MaxDist;
        end
    end

    // Clamp the column to the row and find the end of the row
    always_comb begin
        start_row = i_frame_start || r_await;
        col_c     = (r_col >= r_row_len) ? (r_row_len - COL_W'(1)) : r_col;
        col_inc   = {1'b0, col_c} + (COL_W+1)'(1);
        last      = (col_inc >= {1'b0, r_row_len});
    end

    // Build the item for the reconstruction stage
    always_comb begin
        o_item.is_data   = !start_row;
        o_item.data      = i_stream_byte;
        o_item.kind      = r_kind;
        o_item.slot      = mod_dist(col_c, r_dist);
        o_item.col       = col_c[ADDR_W-1:0];
        o_item.first_row = r_first;
        o_item.last      = last;
    end

    // Hold configuration and advance the row state on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_len <= COL_W'(1);
            r_dist    <= DIST_W'(1);
            r_col     <= '0;
            r_kind    <= '0;
            r_await   <= 1'b1;
            r_first   <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ROW_BYTES:       r_row_len <= cfg_len;
                    CFG_BYTES_PER_PIXEL: r_dist    <= cfg_dist;
                    default:             ;
                endcase
            end
            if (i_accept) begin
                if (start_row) begin
                    r_kind  <= i_stream_byte;
                    r_col   <= '0;
                    r_await <= 1'b0;
                    if (i_frame_start) begin
                        r_first <= 1'b1;
                    end
                end else if (last) begin
                    r_col   <= '0;
                    r_await <= 1'b1;
                    r_first <= 1'b0;
                end else begin
                    r_col <= col_inc[COL_W-1:0];
                end
            end
        end
    end

endmodule

/* design/png_unf_recon.sv */
// ----------------------------------------------------------------------------
// png_unf_recon: byte reconstruction stage and result register
// Applies the row's filter to one byte using the left, up and upper-left
// bytes, updates the pixel history and the line store, and drives results.
// ----------------------------------------------------------------------------
module png_unf_recon
    import png_unf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_item      i_item,
    input  logic [7:0] i_up_byte,
    input  logic       i_out_stall,
    output logic       o_free,
    output t_wr_req    o_wr,
    output logic       o_out_valid,
    output logic [7:0] o_pixel_byte,
    output logic       o_end_of_row
);

    logic              r_s1_valid;
    t_item             r_s1;
    logic [7:0]        r_left  [MAX_PIXEL_BYTES];
    logic [7:0]        r_upper [MAX_PIXEL_BYTES];
    logic              r_out_valid;
    logic [7:0]        r_out_pixel;
    logic              r_out_eor;

    logic              out_free;
    logic              s1_adv;
    logic [7:0]        a_byte;
    logic [7:0]        b_byte;
    logic [7:0]        c_byte;
    logic [8:0]        ab_sum;
    logic [7:0]        pred;
    logic [7:0]        n_pixel;

    // Stage handshake: filter bytes leave without a result
    always_comb begin
        out_free = !r_out_valid || !i_out_stall;
        s1_adv   = r_s1_valid && (!r_s1.is_data || out_free);
        o_free   = !r_s1_valid || s1_adv;
    end

    // Reconstruct the byte
    always_comb begin
        a_byte = r_left[r_s1.slot];
        c_byte = r_upper[r_s1.slot];
        b_byte = r_s1.first_row ? 8'd0 : i_up_byte;
        ab_sum = {1'b0, a_byte} + {1'b0, b_byte};
        case (r_s1.kind)
            FILT_SUB:   pred = a_byte;
            FILT_UP:    pred = b_byte;
            FILT_AVG:   pred = ab_sum[8:1];
            FILT_PAETH: pred = paeth_pred(a_byte, b_byte, c_byte);
            default:    pred = 8'd0;
        endcase
        n_pixel = r_s1.data + pred;
    end

    // Store the byte for the next row
    always_comb begin
        o_wr.en   = s1_adv && r_s1.is_data;
        o_wr.addr = r_s1.col;
        o_wr.data = n_pixel;
    end

    // Control: stage and result valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv && r_s1.is_data) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Pixel history: cleared at each filter byte, updated per data byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
                r_left[i]  <= '0;
                r_upper[i] <= '0;
            end
        end else if (s1_adv) begin
            if (r_s1.is_data) begin
                r_left[r_s1.slot]  <= n_pixel;
                r_upper[r_s1.slot] <= b_byte;
            end else begin
                for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
                    r_left[i]  <= '0;
                    r_upper[i] <= '0;
                end
            end
        end
    end

    // Payload: stage item and result
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s1 <= i_item;
        end
        if (s1_adv && r_s1.is_data) begin
            r_out_pixel <= n_pixel;
            r_out_eor   <= r_s1.last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_byte = r_out_pixel;
    assign o_end_of_row = r_out_eor;

endmodule

/* design/png_scanline_unfilter_core.sv */
// ----------------------------------------------------------------------------
// png_scanline_unfilter_core: PNG scanline filter reconstruction
// Rebuilds None, Sub, Up, Average and Paeth filtered scanlines from the
// inflated byte stream, one byte per clock unless stalled; prior row kept on chip.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-------------------------
//   in      | input     | i_in_valid / o_in_stall  | i_stream_byte, i_frame_start
//   out     | output    | o_out_valid / i_out_stall| o_pixel_byte, o_end_of_row
//   cfg     | input     | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// One byte is taken per cycle while o_in_stall is low. The transfer loads
// the item register and the line store read; the filter arithmetic loads
// the result register from them once the output is free.
// Filter bytes give no result.
// Reset is synchronous; the line store is not cleared, since the first row
// of an image replaces its bytes with zero. A stall on the output holds
// the result and backs up through the reconstruction stage to o_in_stall.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_core
    import png_unf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_stream_byte,
    input  logic                  i_frame_start,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [7:0]            o_pixel_byte,
    output logic                  o_end_of_row
);

    logic       stage_free;
    logic       in_xfer;
    t_item      item;
    t_wr_req    wr_req;
    logic [7:0] up_byte;

    // Input transfer when the reconstruction stage can take a byte
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !stage_free;
    assign in_xfer     = i_in_valid && stage_free;

    png_unf_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (in_xfer),
        .i_stream_byte (i_stream_byte),
        .i_frame_start (i_frame_start),
        .o_item        (item)
    );

    png_unf_line_store u_line_store (
        .i_clk     (i_clk),
        .i_wr      (wr_req),
        .i_rd_en   (in_xfer && item.is_data),
        .i_rd_addr (item.col),
        .o_rd_data (up_byte)
    );

    png_unf_recon u_recon (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (in_xfer),
        .i_item       (item),
        .i_up_byte    (up_byte),
        .i_out_stall  (i_out_stall),
        .o_free       (stage_free),
        .o_wr         (wr_req),
        .o_out_valid  (o_out_valid),
        .o_pixel_byte (o_pixel_byte),
        .o_end_of_row (o_end_of_row)
    );

endmodule
